@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/ftjl_pkg.sv @@
package ftjl_pkg;

    localparam int LEN_W          = 7;
    localparam int SP_W           = 6;
    localparam int CNT_W          = 6;
    localparam int CMP_W          = LEN_W + 2;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int LINE_WIDTH_RST = 16;
    localparam int QUEUE_DEPTH    = 2;

    // One classified word, as handed from the front to the back.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] w;
        logic             pre_flush;
        logic [CNT_W-1:0] pre_n;
        logic [LEN_W-1:0] pre_sum;
        logic             too_long;
        logic             append;
        logic [CNT_W-1:0] wr_idx;
        logic             post_flush;
        logic [CNT_W-1:0] post_n;
        logic [LEN_W-1:0] post_sum;
    } t_cmd;

endpackage

@@ rtl/core/ftjl_ram.sv @@
module ftjl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ftjl_div.sv @@
module ftjl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ftjl_pkg::LEN_W-1:0]  i_dividend,
    input  logic [ftjl_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [ftjl_pkg::LEN_W-1:0]  o_quot,
    output logic [ftjl_pkg::CNT_W-1:0]  o_rem
);

    localparam int LW     = ftjl_pkg::LEN_W;
    localparam int CW     = ftjl_pkg::CNT_W;
    localparam int STEP_W = $clog2(LW + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [LW-1:0]     r_quot;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_divisor;
    logic [CW:0]       trial;
    logic [CW:0]       diff;
    logic              fits;

    // Restoring division, one quotient bit per cycle.
    assign trial = {r_rem, r_quot[LW-1]};
    assign fits  = trial >= {1'b0, r_divisor};
    assign diff  = trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(LW);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[LW-2:0], fits};
            r_rem  <= fits ? diff[CW-1:0] : trial[CW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

@@ rtl/core/ftjl_cmd_fifo.sv @@
`include "assert_macros.svh"

module ftjl_cmd_fifo #(
    parameter int DEPTH = ftjl_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ftjl_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ftjl_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    ftjl_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [FILL_W-1:0] r_fill;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] nx;
        nx = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return nx;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_cmd   = r_mem[r_rd];

    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(DEPTH), "queue overfilled")
    `ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_fill != '0, "pop from empty queue")

endmodule

@@ rtl/core/ftjl_front.sv @@
module ftjl_front #(
    parameter int MAX_WIDTH = ftjl_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ftjl_pkg::LEN_W-1:0] i_word_length,
    input  logic                       i_final_word,
    input  logic [ftjl_pkg::LEN_W-1:0] i_line_width,
    output logic                       o_push,
    output ftjl_pkg::t_cmd             o_cmd,
    input  logic                       i_full
);

    localparam int LW         = ftjl_pkg::LEN_W;
    localparam int CW         = ftjl_pkg::CNT_W;
    localparam int XW         = ftjl_pkg::CMP_W;
    localparam int PEND_DEPTH = (MAX_WIDTH + 1) / 2;

    logic [CW-1:0] r_count;
    logic [LW-1:0] r_sum;
    logic [CW-1:0] n_count;
    logic [LW-1:0] n_sum;

    logic [LW-1:0] len_n;
    logic [LW-1:0] w_n;
    logic          pre;
    logic          tl;
    logic          app;
    logic          post;
    logic [CW-1:0] cnt1;
    logic [CW-1:0] cnt2;
    logic [LW-1:0] sum1;
    logic [LW-1:0] sum2;

    // The front tracks the line being filled and decides, per word, which
    // lines the back has to emit.
    always_comb begin
        len_n = (i_word_length == '0) ? LW'(1) : i_word_length;
        if (i_line_width == '0) begin
            w_n = LW'(1);
        end else if (i_line_width > LW'(MAX_WIDTH)) begin
            w_n = LW'(MAX_WIDTH);
        end else begin
            w_n = i_line_width;
        end
        pre  = (r_count != '0) &&
               ((XW'(r_sum) + XW'(r_count) + XW'(len_n)) > XW'(w_n));
        cnt1 = pre ? '0 : r_count;
        sum1 = pre ? '0 : r_sum;
        tl   = len_n > w_n;
        app  = !tl && (cnt1 < CW'(PEND_DEPTH));
        cnt2 = app ? cnt1 + CW'(1) : cnt1;
        sum2 = app ? sum1 + len_n : sum1;
        post = !tl && i_final_word && (cnt2 != '0);

        n_count = post ? '0 : cnt2;
        n_sum   = post ? '0 : sum2;

        o_cmd.len        = len_n;
        o_cmd.w          = w_n;
        o_cmd.pre_flush  = pre;
        o_cmd.pre_n      = r_count;
        o_cmd.pre_sum    = r_sum;
        o_cmd.too_long   = tl;
        o_cmd.append     = app;
        o_cmd.wr_idx     = cnt1;
        o_cmd.post_flush = post;
        o_cmd.post_n     = cnt2;
        o_cmd.post_sum   = sum2;
    end

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (o_push) begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

@@ rtl/core/ftjl_back.sv @@
`include "assert_macros.svh"

module ftjl_back #(
    parameter int MAX_WIDTH = ftjl_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  ftjl_pkg::t_cmd             i_cmd,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ftjl_pkg::LEN_W-1:0] o_out_length,
    output logic [ftjl_pkg::SP_W-1:0]  o_spaces_after,
    output logic                       o_line_end,
    output logic                       o_too_long,
    output logic                       o_run_last
);

    localparam int LW         = ftjl_pkg::LEN_W;
    localparam int SW         = ftjl_pkg::SP_W;
    localparam int CW         = ftjl_pkg::CNT_W;
    localparam int PEND_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int ADDR_W     = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_WORD  = 3'd5;

    logic [2:0]     r_state, n_state;
    ftjl_pkg::t_cmd r_cmd, n_cmd;
    logic [CW-1:0]  r_n, n_n;
    logic [LW-1:0]  r_sum, n_sum;
    logic           r_last, n_last;
    logic           r_post, n_post;
    logic [LW-1:0]  r_each, n_each;
    logic [CW-1:0]  r_rem, n_rem;
    logic [LW-1:0]  r_pad, n_pad;
    logic [CW-1:0]  r_idx, n_idx;

    logic           r_out_valid;
    logic [LW-1:0]  r_out_length;
    logic [SW-1:0]  r_out_spaces;
    logic           r_out_line_end;
    logic           r_out_too_long;
    logic           r_out_run_last;

    logic           load;
    logic [LW-1:0]  ld_len;
    logic [SW-1:0]  ld_sp;
    logic           ld_end;
    logic           ld_tl;
    logic           ld_rl;
    logic           out_free;

    logic [CW-1:0]  gaps;
    logic [LW:0]    total;
    logic [LW:0]    w_ext;
    logic           simple;
    logic           short_line;
    logic [LW-1:0]  pad_simple;
    logic           last_i;
    logic [LW-1:0]  sp_full;

    logic           div_start;
    logic           div_done;
    logic [LW-1:0]  div_quot;
    logic [CW-1:0]  div_rem;
    logic [LW-1:0]  ram_rdata;
    logic           ram_we;
    logic           ram_re;

    assign ram_we = (r_state == S_WORD) && !r_cmd.too_long && r_cmd.append;
    assign ram_re = (r_state == S_READ);

    ftjl_ram #(
        .WIDTH (LW),
        .DEPTH (PEND_DEPTH)
    ) u_words (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cmd.wr_idx[ADDR_W-1:0]),
        .i_wdata (r_cmd.len),
        .i_re    (ram_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    ftjl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cmd.w - r_sum),
        .i_divisor  (gaps),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        gaps       = r_n - CW'(1);
        total      = {1'b0, r_sum} + (LW + 1)'(gaps);
        w_ext      = {1'b0, r_cmd.w};
        simple     = (r_n == CW'(1)) || r_last;
        short_line = w_ext < total;
        pad_simple = (w_ext > total) ? LW'(w_ext - total) : '0;
        last_i     = (r_idx == gaps);
        sp_full    = last_i ? r_pad : r_each + LW'(r_idx < r_rem);
        out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_n       = r_n;
        n_sum     = r_sum;
        n_last    = r_last;
        n_post    = r_post;
        n_each    = r_each;
        n_rem     = r_rem;
        n_pad     = r_pad;
        n_idx     = r_idx;
        load      = 1'b0;
        ld_len    = r_cmd.len;
        ld_sp     = '0;
        ld_end    = 1'b1;
        ld_tl     = 1'b1;
        ld_rl     = 1'b1;
        o_pop     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    if (i_cmd.pre_flush) begin
                        n_n     = i_cmd.pre_n;
                        n_sum   = i_cmd.pre_sum;
                        n_last  = 1'b0;
                        n_post  = 1'b0;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_WORD;
                    end
                end
            end
            S_SETUP: begin
                n_idx  = '0;
                n_each = LW'(1);
                n_rem  = '0;
                n_pad  = '0;
                if (simple) begin
                    n_pad   = pad_simple;
                    n_state = S_READ;
                end else if (short_line) begin
                    n_state = S_READ;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_each  = div_quot;
                    n_rem   = div_rem;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    load   = 1'b1;
                    ld_len = ram_rdata;
                    ld_sp  = sp_full[SW-1:0];
                    ld_end = last_i;
                    ld_tl  = 1'b0;
                    ld_rl  = last_i &&
                             (r_post || (!r_cmd.too_long && !r_cmd.post_flush));
                    if (last_i) begin
                        n_state = r_post ? S_IDLE : S_WORD;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_WORD: begin
                if (r_cmd.too_long) begin
                    if (out_free) begin
                        load    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_cmd.post_flush) begin
                    n_n     = r_cmd.post_n;
                    n_sum   = r_cmd.post_sum;
                    n_last  = 1'b1;
                    n_post  = 1'b1;
                    n_state = S_SETUP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_n    <= n_n;
        r_sum  <= n_sum;
        r_last <= n_last;
        r_post <= n_post;
        r_each <= n_each;
        r_rem  <= n_rem;
        r_pad  <= n_pad;
        r_idx  <= n_idx;
        if (load) begin
            r_out_length   <= ld_len;
            r_out_spaces   <= ld_sp;
            r_out_line_end <= ld_end;
            r_out_too_long <= ld_tl;
            r_out_run_last <= ld_rl;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_length   = r_out_length;
    assign o_spaces_after = r_out_spaces;
    assign o_line_end     = r_out_line_end;
    assign o_too_long     = r_out_too_long;
    assign o_run_last     = r_out_run_last;

    `ASSERT_IMPLIES(a_emit_in_line, i_clk, i_rst_n, r_state == S_EMIT, r_idx < r_n, "word index past end of line")
    `ASSERT_IMPLIES(a_div_rem, i_clk, i_rst_n, div_done, div_rem < gaps, "gap remainder not below gap count")
    `ASSERT_IMPLIES(a_long_alone, i_clk, i_rst_n, r_out_valid && r_out_too_long, r_out_line_end && (r_out_spaces == '0) && r_out_run_last, "oversize word not alone on its line")

endmodule

@@ rtl/core/full_text_justify_layout_core.sv @@
// Full-justification line layout. Each input transaction carries one word
// length and a final-word mark; each output transaction carries one placed
// word: its length, the blank columns after it, a line-end mark, an oversize
// mark, and a mark on the last result caused by the input transaction.
// Words are packed greedily into lines of the configured width. A line is
// emitted when the next word does not fit, or at the final word (then left
// justified with single gaps). A word wider than the line stands alone.
// The line width is written through the configuration channel; the user must
// write it only while the block is idle, and the block itself leaves this
// unenforced. The channel is always ready; the width resets to 16 columns.
// The front classifies words into a two-entry command queue; the back emits.
// A word that only joins a line occupies the back in its idle and word
// states, and the front keeps taking words while the queue has room. A line
// is emitted from a setup state, then a read and an emit state per word; the
// iterative gap divider runs after setup whenever a line of two or more words
// is spread to the full width.
// Results leave through one output register; while the receiver stalls the
// back holds, the queue fills, and then input ready drops. Nothing is lost.
// Reset is synchronous and active low; it empties the line and the queue.
module full_text_justify_layout_core #(
    parameter int MAX_WIDTH = ftjl_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ftjl_pkg::LEN_W-1:0] i_word_length,
    input  logic                       i_final_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ftjl_pkg::LEN_W-1:0] o_out_length,
    output logic [ftjl_pkg::SP_W-1:0]  o_spaces_after,
    output logic                       o_line_end,
    output logic                       o_too_long,
    output logic                       o_run_last,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ftjl_pkg::LEN_W-1:0] i_cfg_data
);

    // Configured line width; clamping to the legal range happens in the front.
    logic [ftjl_pkg::LEN_W-1:0] r_line_width;

    ftjl_pkg::t_cmd push_cmd;
    ftjl_pkg::t_cmd pop_cmd;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= ftjl_pkg::LEN_W'(ftjl_pkg::LINE_WIDTH_RST);
        end else if (i_cfg_valid) begin
            r_line_width <= i_cfg_data;
        end
    end

    // Front: normalizes the word, tracks the line fill, and decides which
    // lines must be emitted for this word.
    ftjl_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_word_length (i_word_length),
        .i_final_word  (i_final_word),
        .i_line_width  (r_line_width),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_full        (full)
    );

    // Command queue lets the front keep taking words while a line drains.
    ftjl_cmd_fifo #(
        .DEPTH (ftjl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (pop_cmd)
    );

    // Back: stores buffered words, spreads the blanks and emits the results.
    ftjl_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_cmd          (pop_cmd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_length   (o_out_length),
        .o_spaces_after (o_spaces_after),
        .o_line_end     (o_line_end),
        .o_too_long     (o_too_long),
        .o_run_last     (o_run_last)
    );

endmodule

@@ tb/sv/tb_full_text_justify_layout_core.sv @@
`timescale 1ns / 1ps

module tb_full_text_justify_layout_core;

    // The line buffer of the block holds at most this many words.
    localparam int LINE_SLOTS    = (ftjl_pkg::MAX_WIDTH_DEF + 1) / 2;
    // Quiet cycles allowed before the run is declared hung.
    localparam int HANG_LIMIT    = 4000;
    // Cycles to wait after the last expected result, since a word that only
    // joins a line produces nothing but may still be in flight.
    localparam int SETTLE_CYCLES = 100;
    localparam int RESET_CYCLES  = 12;
    localparam int HEAVY_PCT     = 79;
    localparam int MIXED_PCT     = 31;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_WORDS   = 62;

    // One word offered to the block.
    typedef struct {
        logic [ftjl_pkg::LEN_W-1:0] len;
        logic                       fin;
    } t_word;

    // One placed word as the block reports it.
    typedef struct packed {
        logic [ftjl_pkg::LEN_W-1:0] len;
        logic [ftjl_pkg::SP_W-1:0]  gap;
        logic                       eol;
        logic                       oversize;
        logic                       run_last;
    } t_placed;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_in_valid     = 1'b0;
    logic                         o_in_ready;
    logic [ftjl_pkg::LEN_W-1:0]   i_word_length  = '0;
    logic                         i_final_word   = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready    = 1'b0;
    logic [ftjl_pkg::LEN_W-1:0]   o_out_length;
    logic [ftjl_pkg::SP_W-1:0]    o_spaces_after;
    logic                         o_line_end;
    logic                         o_too_long;
    logic                         o_run_last;
    logic                         i_cfg_valid    = 1'b0;
    logic                         o_cfg_ready;
    logic [ftjl_pkg::LEN_W-1:0]   i_cfg_data     = '0;

    // Words waiting to be driven, and the placed words the block owes us.
    t_word                        word_q[$];
    t_placed                      placed_q[$];

    // Our own copy of the block's line buffer and width register.
    logic [ftjl_pkg::LEN_W-1:0]   width_reg = ftjl_pkg::LEN_W'(ftjl_pkg::LINE_WIDTH_RST);
    int                           line_len[LINE_SLOTS];
    int                           line_cnt  = 0;
    int                           line_sum  = 0;

    int                           sender_idle_pct    = 0;
    int                           receiver_stall_pct = 0;
    int                           fail_count         = 0;
    int                           quiet_cycles       = 0;

    always #2ns i_clk = ~i_clk;

    full_text_justify_layout_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_word_length  (i_word_length),
        .i_final_word   (i_final_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_length   (o_out_length),
        .o_spaces_after (o_spaces_after),
        .o_line_end     (o_line_end),
        .o_too_long     (o_too_long),
        .o_run_last     (o_run_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // Record one placed word that the block must report.
    function automatic void place_word(input int len, input int gap, input bit eol,
                                       input bit oversize);
        t_placed p;
        p.len      = ftjl_pkg::LEN_W'(len);
        p.gap      = ftjl_pkg::SP_W'(gap);
        p.eol      = eol;
        p.oversize = oversize;
        p.run_last = 1'b0;
        placed_q.insert(placed_q.size(), p);
    endfunction

    // Lay out the buffered line. A closing line gets single gaps and is padded
    // at its end. Otherwise the blanks are spread over the gaps with the left
    // gaps taking the remainder, unless the line no longer fits after a width
    // change, in which case it goes out with single gaps and no padding.
    function automatic void emit_line(input int w, input bit closing);
        int n;
        int each;
        int rem;
        int pad;
        int gap;
        n    = line_cnt;
        each = 1;
        rem  = 0;
        pad  = 0;
        if (n == 0)
            return;
        if (n == 1) begin
            pad = (w > line_sum) ? w - line_sum : 0;
        end else if (closing || w < line_sum + n - 1) begin
            pad = (closing && w > line_sum + n - 1) ? w - line_sum - (n - 1) : 0;
        end else begin
            each = (w - line_sum) / (n - 1);
            rem  = (w - line_sum) % (n - 1);
        end
        for (int i = 0; i < n; i++) begin
            gap = (i == n - 1) ? pad : each + ((i < rem) ? 1 : 0);
            place_word(line_len[i], gap, i == n - 1, 1'b0);
        end
        line_cnt = 0;
        line_sum = 0;
    endfunction

    // Work out everything one accepted word causes and queue it as owed.
    function automatic void layout_word(input logic [ftjl_pkg::LEN_W-1:0] raw_len,
                                        input logic fin);
        int      len;
        int      w;
        int      owed_before;
        t_placed p;
        owed_before = placed_q.size();
        len = (raw_len == '0) ? 1 : int'(raw_len);
        w   = (width_reg == '0) ? 1 : int'(width_reg);
        if (w > ftjl_pkg::MAX_WIDTH_DEF)
            w = ftjl_pkg::MAX_WIDTH_DEF;
        if (line_cnt > 0 && line_sum + line_cnt + len > w)
            emit_line(w, 1'b0);
        if (len > w) begin
            // Oversized words stand alone on their own line.
            place_word(len, 0, 1'b1, 1'b1);
        end else begin
            if (line_cnt < LINE_SLOTS) begin
                line_len[line_cnt] = len;
                line_cnt++;
                line_sum += len;
            end
            if (fin)
                emit_line(w, 1'b1);
        end
        if (placed_q.size() > owed_before) begin
            p = placed_q.pop_back();
            p.run_last = 1'b1;
            placed_q.insert(placed_q.size(), p);
        end
    endfunction

    // Input driver. A word stays on the bus until its transaction completes;
    // between words the sender may idle at random.
    always @(posedge i_clk) begin : word_driver
        t_word nxt;
        if (i_in_valid && o_in_ready)
            layout_word(i_word_length, i_final_word);
        if (!i_in_valid || o_in_ready) begin
            if (i_rst_n && word_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                nxt = word_q.pop_front();
                i_in_valid    <= 1'b1;
                i_word_length <= nxt.len;
                i_final_word  <= nxt.fin;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor. Every completed output transaction is matched against
    // the oldest owed placed word, field by field.
    always @(posedge i_clk) begin : placed_monitor
        t_placed p;
        if (o_out_valid && i_out_ready) begin
            if (placed_q.size() == 0) begin
                $error("unexpected result: length %0d spaces %0d", o_out_length,
                       o_spaces_after);
                fail_count++;
            end else begin
                p = placed_q.pop_front();
                if (o_out_length !== p.len) begin
                    $error("out_length: expected %0d, actual %0d", p.len, o_out_length);
                    fail_count++;
                end
                if (o_spaces_after !== p.gap) begin
                    $error("spaces_after: expected %0d, actual %0d", p.gap, o_spaces_after);
                    fail_count++;
                end
                if (o_line_end !== p.eol) begin
                    $error("line_end: expected %0d, actual %0d", p.eol, o_line_end);
                    fail_count++;
                end
                if (o_too_long !== p.oversize) begin
                    $error("too_long: expected %0d, actual %0d", p.oversize, o_too_long);
                    fail_count++;
                end
                if (o_run_last !== p.run_last) begin
                    $error("run_last: expected %0d, actual %0d", p.run_last, o_run_last);
                    fail_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: any cycle without a completed transaction counts toward a hang.
    always @(posedge i_clk) begin : hang_watch
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_word(input int len, input bit fin);
        t_word item;
        item.len = ftjl_pkg::LEN_W'(len);
        item.fin = fin;
        word_q.insert(word_q.size(), item);
    endtask

    // Wait until every word is accepted and every owed result has arrived,
    // then let the block finish any word that produces nothing.
    task automatic settle();
        do @(posedge i_clk);
        while (word_q.size() != 0 || i_in_valid || placed_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Width writes only happen while the block is idle.
    task automatic write_width(input logic [ftjl_pkg::LEN_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        width_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Word lengths for a given effective width: many short words so lines
    // fill up with lots of gaps, a few zero-length and oversized words.
    function automatic int pick_len(input int w);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 0;
        if (r < 10)
            return $urandom_range(127, w + 1);
        if (r < 20)
            return 1;
        if (r < 55)
            return $urandom_range((w < 4) ? w : 4, 1);
        return $urandom_range(w, 1);
    endfunction

    // Random texts: runs of words closed by a final mark, with stray final
    // marks as noise. The last text of a phase may be cut short so that a
    // width change lands in the middle of a line.
    task automatic queue_texts(input int count, input int w);
        int left;
        int text_len;
        int i;
        left = count;
        while (left > 0) begin
            text_len = $urandom_range(24, 1);
            for (i = 0; i < text_len && left > 0; i++) begin
                push_word(pick_len(w), (i == text_len - 1) || ($urandom_range(99) < 3));
                left--;
            end
        end
    endtask

    initial begin : stimulus
        logic [ftjl_pkg::LEN_W-1:0] widths[RAND_PHASES];
        int                         w_eff;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset width of 16 columns.
        push_word(3, 0);        // three words, even gaps when the fourth spills
        push_word(4, 0);
        push_word(5, 0);
        push_word(6, 0);
        push_word(10, 0);       // lone word padded on its right
        push_word(20, 0);       // oversized word after a buffered line
        push_word(127, 0);      // oversized with an empty line, all bits set
        push_word(0, 0);        // zero length counts as one
        push_word(2, 0);
        push_word(4, 0);
        push_word(9, 0);        // uneven gaps, the left gap takes the remainder
        push_word(16, 0);       // exactly the line width
        push_word(1, 1);        // final word that spills the line first
        push_word(2, 0);
        push_word(3, 0);
        push_word(4, 1);        // final line left-justified and padded
        push_word(40, 1);       // oversized final word
        push_word(64, 0);
        push_word(7, 0);
        push_word(8, 0);        // fills the line exactly, left buffered
        settle();

        // Shrink the width under a buffered line: it must go out unpadded.
        write_width(ftjl_pkg::LEN_W'(4));
        push_word(3, 0);
        settle();
        // Zero width acts as one column.
        write_width('0);
        push_word(1, 1);
        settle();

        widths[0] = ftjl_pkg::LEN_W'(64);
        widths[1] = ftjl_pkg::LEN_W'(1);
        widths[2] = ftjl_pkg::LEN_W'(127);
        widths[3] = ftjl_pkg::LEN_W'(16);
        widths[4] = ftjl_pkg::LEN_W'($urandom_range(63, 2));
        widths[5] = ftjl_pkg::LEN_W'(65);
        widths[6] = ftjl_pkg::LEN_W'(33);
        widths[7] = ftjl_pkg::LEN_W'($urandom_range(63, 2));

        // Random phases, cycling through the idle patterns of both sides.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = HEAVY_PCT;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = HEAVY_PCT;
                end
                default: begin
                    sender_idle_pct    = MIXED_PCT;
                    receiver_stall_pct = MIXED_PCT;
                end
            endcase
            write_width(widths[ph]);
            w_eff = (widths[ph] == '0) ? 1 : int'(widths[ph]);
            if (w_eff > ftjl_pkg::MAX_WIDTH_DEF)
                w_eff = ftjl_pkg::MAX_WIDTH_DEF;
            queue_texts(PHASE_WORDS, w_eff);
            settle();
        end

        if (placed_q.size() != 0) begin
            $error("%0d expected results never arrived", placed_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ full_text_justify_layout_core.f @@
+incdir+rtl/core
rtl/core/ftjl_pkg.sv
rtl/core/ftjl_ram.sv
rtl/core/ftjl_div.sv
rtl/core/ftjl_cmd_fifo.sv
rtl/core/ftjl_front.sv
rtl/core/ftjl_back.sv
rtl/core/full_text_justify_layout_core.sv
tb/sv/tb_full_text_justify_layout_core.sv
